/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VIAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VIAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/viat_pkg.sv */
// Types and constants for the interface adapter with timers.
// No dependencies; imported by the core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package viat_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// register numbers
	localparam logic [3:0] REG_PORT_B  = 4'd0;
	localparam logic [3:0] REG_DIR_B   = 4'd2;
	localparam logic [3:0] REG_DIR_A   = 4'd3;
	localparam logic [3:0] REG_T1_CL   = 4'd4;
	localparam logic [3:0] REG_T1_CH   = 4'd5;
	localparam logic [3:0] REG_T1_LL   = 4'd6;
	localparam logic [3:0] REG_T1_LH   = 4'd7;
	localparam logic [3:0] REG_T2_L    = 4'd8;
	localparam logic [3:0] REG_T2_H    = 4'd9;
	localparam logic [3:0] REG_SHIFT   = 4'd10;
	localparam logic [3:0] REG_AUX     = 4'd11;
	localparam logic [3:0] REG_PERIPH  = 4'd12;
	localparam logic [3:0] REG_FLAGS   = 4'd13;
	localparam logic [3:0] REG_ENABLES = 4'd14;
	localparam logic [3:0] REG_PORT_A  = 4'd15;

	// interrupt flag groups
	localparam logic [6:0] FLAG_CA = 7'b0000011;
	localparam logic [6:0] FLAG_SR = 7'b0000100;
	localparam logic [6:0] FLAG_CB = 7'b0011000;
	localparam logic [6:0] FLAG_T2 = 7'b0100000;
	localparam logic [6:0] FLAG_T1 = 7'b1000000;

	localparam logic [7:0] PB_OUT_MASK  = 8'b00111000;
	localparam logic [7:0] PB_FIXED_ONE = 8'b00001000;
	localparam logic [7:0] PA_READ_MASK = 8'b11101111;
	localparam logic [7:0] READ_TOP_BIT = 8'b10000000;

	typedef struct packed {
		logic [2:0] clock_chip_in;
		logic       hblank_in;
		logic       sound_on_in;
		logic [7:0] port_a_in;
		logic [7:0] wdata;
		logic [3:0] reg_index;
		cmd_t       cmd;
	} item_t;

	typedef struct packed {
		logic [2:0] clock_chip_out;
		logic       head_select;
		logic       overlay_sel;
		logic       sound_level;
		logic       irq;
		logic [7:0] rdata;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/viat_core.sv */
// Register file, port logic and timers of the interface adapter.
// Depends on viat_pkg. One request is applied per cycle when step is high.
`timescale 1ns / 1ps
`default_nettype none

module viat_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire viat_pkg::item_t  item,
	output viat_pkg::result_t     res
);
	import viat_pkg::*;

	logic [6:0]  flags_q, enables_q;
	logic [7:0]  dir_a_q, dir_b_q, out_a_q, out_b_q;
	logic [15:0] t1_latch_q, t1_count_q, t2_latch_q, t2_count_q;
	logic        t1_run_q, t2_run_q;
	logic [7:0]  shift_q, aux_q, periph_q;
	logic        sound_q, overlay_q;

	logic [6:0]  flags_d, enables_d;
	logic [7:0]  dir_a_d, dir_b_d, out_a_d, out_b_d;
	logic [15:0] t1_latch_d, t1_count_d, t2_latch_d, t2_count_d;
	logic        t1_run_d, t2_run_d;
	logic [7:0]  shift_d, aux_d, periph_d;
	logic        sound_d, overlay_d;
	logic [7:0]  rd;
	logic [7:0]  pb_pins;
	logic [7:0]  eff_a;

	assign pb_pins = {item.sound_on_in, item.hblank_in, 3'b000, item.clock_chip_in};

	always_comb begin
		flags_d    = flags_q;
		enables_d  = enables_q;
		dir_a_d    = dir_a_q;
		dir_b_d    = dir_b_q;
		out_a_d    = out_a_q;
		out_b_d    = out_b_q;
		t1_latch_d = t1_latch_q;
		t1_count_d = t1_count_q;
		t2_latch_d = t2_latch_q;
		t2_count_d = t2_count_q;
		t1_run_d   = t1_run_q;
		t2_run_d   = t2_run_q;
		shift_d    = shift_q;
		aux_d      = aux_q;
		periph_d   = periph_q;
		sound_d    = sound_q;
		overlay_d  = overlay_q;
		rd         = '0;

		case (item.cmd)
			CMD_READ: begin
				case (item.reg_index)
					REG_PORT_B: begin
						flags_d = flags_q & ~FLAG_CB;
						rd = (pb_pins & ~dir_b_q) | (out_b_q & PB_OUT_MASK) | PB_FIXED_ONE
							| (out_b_q & dir_b_q);
					end
					REG_DIR_B: rd = dir_b_q;
					REG_DIR_A: rd = dir_a_q;
					REG_T1_CL: begin
						flags_d = flags_q & ~FLAG_T1;
						rd = t1_count_q[7:0];
					end
					REG_T1_CH: rd = t1_count_q[15:8];
					REG_T1_LL: rd = t1_latch_q[7:0];
					REG_T1_LH: rd = t1_latch_q[15:8];
					REG_T2_L: begin
						flags_d = flags_q & ~FLAG_T2;
						rd = t2_count_q[7:0];
					end
					REG_T2_H: rd = t2_count_q[15:8];
					REG_SHIFT: begin
						flags_d = flags_q & ~FLAG_SR;
						rd = shift_q;
					end
					REG_AUX:     rd = aux_q;
					REG_PERIPH:  rd = periph_q;
					REG_FLAGS:   rd = {|flags_q, flags_q};
					REG_ENABLES: rd = {1'b1, enables_q};
					REG_PORT_A: begin
						flags_d = flags_q & ~FLAG_CA;
						rd = (out_a_q & PA_READ_MASK) | {3'b000, overlay_q, 4'b0000}
							| READ_TOP_BIT;
					end
					default: rd = '0;
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_index)
					REG_PORT_B: begin
						flags_d = flags_q & ~FLAG_CB;
						out_b_d = item.wdata;
						sound_d = item.wdata[7] & dir_b_q[7];
					end
					REG_DIR_B: begin
						dir_b_d = item.wdata;
						sound_d = out_b_q[7] & item.wdata[7];
					end
					REG_DIR_A: begin
						dir_a_d = item.wdata;
						overlay_d = item.wdata[4] ? out_a_q[4] : item.port_a_in[4];
					end
					REG_T1_CL, REG_T1_LL: t1_latch_d = {t1_latch_q[15:8], item.wdata};
					REG_T1_CH: begin
						flags_d = flags_q & ~FLAG_T1;
						t1_latch_d = {item.wdata, t1_latch_q[7:0]};
						t1_count_d = {item.wdata, t1_latch_q[7:0]};
						t1_run_d = 1'b1;
						// timer 1 owns PB7: drop the level on reload
						if (aux_q[7] & dir_b_q[7]) begin
							sound_d = 1'b0;
						end
					end
					REG_T1_LH: t1_latch_d = {item.wdata, t1_latch_q[7:0]};
					REG_T2_L:  t2_latch_d = {t2_latch_q[15:8], item.wdata};
					REG_T2_H: begin
						flags_d = flags_q & ~FLAG_T2;
						t2_latch_d = {item.wdata, t2_latch_q[7:0]};
						t2_count_d = {item.wdata, t2_latch_q[7:0]};
						t2_run_d = 1'b1;
					end
					REG_SHIFT: begin
						flags_d = flags_q & ~FLAG_SR;
						shift_d = item.wdata;
					end
					REG_AUX:    aux_d = item.wdata;
					REG_PERIPH: periph_d = item.wdata;
					REG_FLAGS:  flags_d = flags_q & ~item.wdata[6:0];
					REG_ENABLES: begin
						if (item.wdata[7]) begin
							enables_d = enables_q | item.wdata[6:0];
						end else begin
							enables_d = enables_q & ~item.wdata[6:0];
						end
					end
					REG_PORT_A: begin
						flags_d = flags_q & ~FLAG_CA;
						out_a_d = item.wdata;
						overlay_d = dir_a_q[4] ? item.wdata[4] : item.port_a_in[4];
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (t1_run_q) begin
					if (t1_count_q == '0) begin
						if (aux_q[7] & dir_b_q[7]) begin
							sound_d = 1'b1;
						end
						flags_d = flags_d | FLAG_T1;
						// free-running reloads from the latch, one-shot stops
						if (aux_q[6]) begin
							t1_count_d = t1_latch_q;
						end else begin
							t1_run_d = 1'b0;
						end
					end else begin
						t1_count_d = t1_count_q - 16'd1;
					end
				end
				if (t2_run_q && t2_count_q == '0) begin
					flags_d = flags_d | FLAG_T2;
					t2_run_d = 1'b0;
				end
				t2_count_d = t2_count_q - 16'd1;
			end
			default: ;
		endcase
	end

	assign eff_a = (out_a_d & dir_a_d) | (item.port_a_in & ~dir_a_d);

	always_comb begin
		res.rdata          = rd;
		res.irq            = |(flags_d & enables_d);
		res.sound_level    = sound_d;
		res.overlay_sel    = overlay_d;
		res.head_select    = eff_a[5];
		res.clock_chip_out = out_b_d[2:0] & dir_b_d[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			enables_q  <= '0;
			dir_a_q    <= '0;
			dir_b_q    <= '0;
			out_a_q    <= '0;
			out_b_q    <= '0;
			t1_latch_q <= '0;
			t1_count_q <= '0;
			t2_latch_q <= '0;
			t2_count_q <= '0;
			t1_run_q   <= 1'b0;
			t2_run_q   <= 1'b0;
			shift_q    <= '0;
			aux_q      <= '0;
			periph_q   <= '0;
			sound_q    <= 1'b0;
			overlay_q  <= 1'b0;
		end else if (step) begin
			flags_q    <= flags_d;
			enables_q  <= enables_d;
			dir_a_q    <= dir_a_d;
			dir_b_q    <= dir_b_d;
			out_a_q    <= out_a_d;
			out_b_q    <= out_b_d;
			t1_latch_q <= t1_latch_d;
			t1_count_q <= t1_count_d;
			t2_latch_q <= t2_latch_d;
			t2_count_q <= t2_count_d;
			t1_run_q   <= t1_run_d;
			t2_run_q   <= t2_run_d;
			shift_q    <= shift_d;
			aux_q      <= aux_d;
			periph_q   <= periph_d;
			sound_q    <= sound_d;
			overlay_q  <= overlay_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/versatile_interface_adapter_timers.sv */
// Top level of the interface adapter with timers: stream ports, input and result registers.
// Depends on viat_pkg and viat_core.
`timescale 1ns / 1ps
`default_nettype none

// Each request (read, write or timer tick) is taken into an input register, applied to
// the register file when the output side can advance, and its result shown from a result
// register loaded in that same step. One request is taken every clock while the output is
// not stalled; the single register-file update stage sets that figure. While a result waits on m_tready
// the input register still takes one more request.
module versatile_interface_adapter_timers (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [3:0] reg_index, [11:4] wdata, [19:12] port_a_in, [20] sound_on_in,
	// [21] hblank_in, [24:22] clock_chip_in, [31:25] zero
	input  wire logic [31:0] s_tdata,
	// [1:0] cmd
	input  wire logic [1:0]  s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [7:0] rdata, [8] irq, [9] sound_level, [10] overlay_sel, [11] head_select,
	// [14:12] clock_chip_out, [15] zero
	output      logic [15:0] m_tdata
);
	import viat_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    advance;
	logic    step;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd           <= cmd_t'(s_tuser);
			item_s1.reg_index     <= s_tdata[3:0];
			item_s1.wdata         <= s_tdata[11:4];
			item_s1.port_a_in     <= s_tdata[19:12];
			item_s1.sound_on_in   <= s_tdata[20];
			item_s1.hblank_in     <= s_tdata[21];
			item_s1.clock_chip_in <= s_tdata[24:22];
		end
		if (step) begin
			res_q <= res;
		end
	end

	viat_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

endmodule

`default_nettype wire

/* hw/rtl/viat_checker.sv */
// Port-level checks for the interface adapter with timers, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module viat_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// a stalled result holds
	`VIAT_ASSERT_NEXT(a_res_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// input side only stalls when a result is waiting on the output side
	`VIAT_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// padding bit of the result stays clear
	`VIAT_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[15] == 1'b0)

	// a request taken while the output is empty leads to a valid result on the output
	`VIAT_ASSERT_IMPLY(a_no_loss, clk, arst_n, s_tvalid && s_tready && !m_tvalid, ##2 m_tvalid)

endmodule

bind versatile_interface_adapter_timers viat_checker u_viat_checker (.*);

`default_nettype wire
